@@ rtl/core/hpm_pkg.sv @@
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types, widths and helpers of the homography point mapper.
// ----------------------------------------------------------------------------
package hpm_pkg;

    // fixed-point formats
    localparam int CFB    = 32;             // coefficient fraction bits
    localparam int PFB    = 12;             // point fraction bits
    localparam int CW     = 48;             // coefficient width
    localparam int PW     = 32;             // point width
    localparam int NCOEF  = 9;
    localparam int IDXW   = 4;
    localparam int CSPLIT = CW / 2;         // split of the coefficient multiply

    // datapath widths
    localparam int PRODW = CW + PW;         // one exact product
    localparam int ACCW  = PRODW + 2;       // sum of three products
    localparam int MW    = ACCW - 1;        // magnitude of a sum
    localparam int NW    = MW + PFB;        // scaled numerator magnitude
    localparam int QB    = PW + 1;          // quotient bits kept before rounding
    localparam int CNTW  = $clog2(QB + 1);

    // request queue between front and back
    localparam int FDEPTH = 4;
    localparam int FAW    = $clog2(FDEPTH);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic                   is_map;
        logic [IDXW-1:0]        idx;
        logic signed [CW-1:0]   coef;
        logic signed [PW-1:0]   x;
        logic signed [PW-1:0]   y;
        logic                   last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // identity matrix entry in coefficient format
    function automatic logic [CW-1:0] coef_reset(input logic [IDXW-1:0] k);
        logic [CW-1:0] v;
        v = '0;
        if (k == IDXW'(0) || k == IDXW'(4) || k == IDXW'(8)) begin
            v[CFB] = 1'b1;
        end
        return v;
    endfunction

endpackage

@@ rtl/core/hpm_front.sv @@
// ----------------------------------------------------------------------------
// hpm_front
// Accepts requests, drops loads to nonexistent coefficients, packs the rest.
// ----------------------------------------------------------------------------
module hpm_front (
    input  logic                          i_push,
    input  logic                          i_action,
    input  logic [hpm_pkg::IDXW-1:0]      i_coef_index,
    input  logic signed [hpm_pkg::CW-1:0] i_coef_value,
    input  logic signed [hpm_pkg::PW-1:0] i_x_in,
    input  logic signed [hpm_pkg::PW-1:0] i_y_in,
    input  logic                          i_last_in,
    input  hpm_pkg::t_qstat               i_qstat,
    output logic                          o_full,
    output logic                          o_wr,
    output hpm_pkg::t_entry               o_entry
);

    logic accept;
    logic keep;

    // acceptance and classification
    assign accept = i_push && !i_qstat.full;
    assign keep   = i_action || (i_coef_index < hpm_pkg::IDXW'(hpm_pkg::NCOEF));
    assign o_wr   = accept && keep;
    assign o_full = i_qstat.full;

    // pack only what the request kind needs
    always_comb begin
        o_entry        = '0;
        o_entry.is_map = i_action;
        if (i_action) begin
            o_entry.x    = i_x_in;
            o_entry.y    = i_y_in;
            o_entry.last = i_last_in;
        end else begin
            o_entry.idx  = i_coef_index;
            o_entry.coef = i_coef_value;
        end
    end

endmodule

@@ rtl/core/hpm_fifo.sv @@
// ----------------------------------------------------------------------------
// hpm_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module hpm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  hpm_pkg::t_entry i_entry,
    input  logic            i_rd,
    output hpm_pkg::t_entry o_entry,
    output hpm_pkg::t_qstat o_qstat
);

    hpm_pkg::t_entry               r_mem [hpm_pkg::FDEPTH];
    logic [hpm_pkg::FAW-1:0]       r_wp;
    logic [hpm_pkg::FAW-1:0]       r_rp;
    logic [hpm_pkg::FAW:0]         r_cnt;
    logic                          do_wr;
    logic                          do_rd;

    assign o_qstat.full  = (r_cnt == (hpm_pkg::FAW+1)'(hpm_pkg::FDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_wr = i_wr && !o_qstat.full;
    assign do_rd = i_rd && !o_qstat.empty;
    assign o_entry = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= r_wp + 1'b1;
            if (do_rd) r_rp <= r_rp + 1'b1;
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_entry;
    end

endmodule

@@ rtl/core/hpm_back.sv @@
// ----------------------------------------------------------------------------
// hpm_back
// Executes requests: coefficient loads, affine sums and the two divisions.
// ----------------------------------------------------------------------------
module hpm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpm_pkg::t_entry               i_entry,
    input  hpm_pkg::t_qstat               i_qstat,
    output logic                          o_rd,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [hpm_pkg::PW-1:0] o_x_out,
    output logic signed [hpm_pkg::PW-1:0] o_y_out,
    output logic [1:0]                    o_status,
    output logic                          o_last_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_MAG  = 6'b000100,
        S_CHK  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    localparam int HW = hpm_pkg::CW - hpm_pkg::CSPLIT;
    localparam int LW = hpm_pkg::CSPLIT + 1;

    t_state                            r_state;
    logic [hpm_pkg::CW-1:0]            r_coef [hpm_pkg::NCOEF];
    logic signed [hpm_pkg::PW-1:0]     r_x;
    logic signed [hpm_pkg::PW-1:0]     r_y;
    logic                              r_last;
    logic [hpm_pkg::IDXW-1:0]          r_k;
    logic [1:0]                        r_row;
    logic [1:0]                        r_col;
    logic                              r_issued;
    logic                              r_p1_v;
    logic [1:0]                        r_p1_row;
    logic signed [HW+hpm_pkg::PW-1:0]  r_pp_hi;
    logic signed [LW+hpm_pkg::PW-1:0]  r_pp_lo;
    logic                              r_p2_v;
    logic [1:0]                        r_p2_row;
    logic signed [hpm_pkg::PRODW-1:0]  r_prod;
    logic signed [hpm_pkg::ACCW-1:0]   r_acc [3];
    logic [hpm_pkg::NW-1:0]            r_nx;
    logic [hpm_pkg::NW-1:0]            r_ny;
    logic [hpm_pkg::MW-1:0]            r_d;
    logic                              r_negx;
    logic                              r_negy;
    logic                              r_zero;
    logic                              r_ovx;
    logic                              r_ovy;
    logic [hpm_pkg::MW-1:0]            r_rx;
    logic [hpm_pkg::MW-1:0]            r_ry;
    logic [hpm_pkg::QB-1:0]            r_lx;
    logic [hpm_pkg::QB-1:0]            r_ly;
    logic [hpm_pkg::QB-1:0]            r_qx;
    logic [hpm_pkg::QB-1:0]            r_qy;
    logic [hpm_pkg::CNTW-1:0]          r_cnt;
    logic                              r_ov;
    logic signed [hpm_pkg::PW-1:0]     r_ox;
    logic signed [hpm_pkg::PW-1:0]     r_oy;
    hpm_pkg::t_status                  r_ost;
    logic                              r_olast;

    logic signed [hpm_pkg::PW-1:0]     n_pt;
    logic [hpm_pkg::CW-1:0]            n_c;
    logic signed [hpm_pkg::PRODW-1:0]  n_prod;
    logic [hpm_pkg::ACCW-1:0]          n_ax;
    logic [hpm_pkg::ACCW-1:0]          n_ay;
    logic [hpm_pkg::ACCW-1:0]          n_az;
    logic [hpm_pkg::MW:0]              n_tx;
    logic [hpm_pkg::MW:0]              n_ty;
    logic                              n_gex;
    logic                              n_gey;
    logic [hpm_pkg::MW:0]              n_subx;
    logic [hpm_pkg::MW:0]              n_suby;
    logic [hpm_pkg::QB:0]              n_qx;
    logic [hpm_pkg::QB:0]              n_qy;
    logic                              n_satx;
    logic                              n_saty;
    logic signed [hpm_pkg::PW-1:0]     n_vx;
    logic signed [hpm_pkg::PW-1:0]     n_vy;
    logic                              slot_free;
    logic                              n_drained;

    assign slot_free = !r_ov || i_pop;
    assign o_rd      = (r_state == S_IDLE) && !i_qstat.empty;
    assign n_drained = r_issued && !r_p1_v && !r_p2_v;

    // operand selection for the shared multiplier
    always_comb begin
        n_c = r_coef[r_k];
        case (r_col)
            2'd0:    n_pt = r_x;
            2'd1:    n_pt = r_y;
            default: n_pt = hpm_pkg::PW'(1) <<< hpm_pkg::PFB;
        endcase
    end

    // recombine the partial products
    assign n_prod = (hpm_pkg::PRODW'(r_pp_hi) <<< hpm_pkg::CSPLIT)
                  + hpm_pkg::PRODW'(r_pp_lo);

    // magnitudes of the affine sums
    assign n_ax = r_acc[0][hpm_pkg::ACCW-1] ? -r_acc[0] : r_acc[0];
    assign n_ay = r_acc[1][hpm_pkg::ACCW-1] ? -r_acc[1] : r_acc[1];
    assign n_az = r_acc[2][hpm_pkg::ACCW-1] ? -r_acc[2] : r_acc[2];

    // one restoring division step for each quotient
    always_comb begin
        n_tx   = {r_rx, r_lx[hpm_pkg::QB-1]};
        n_ty   = {r_ry, r_ly[hpm_pkg::QB-1]};
        n_gex  = n_tx >= {1'b0, r_d};
        n_gey  = n_ty >= {1'b0, r_d};
        n_subx = n_tx - {1'b0, r_d};
        n_suby = n_ty - {1'b0, r_d};
    end

    // rounding and saturation
    always_comb begin
        n_qx = {1'b0, r_qx} + (hpm_pkg::QB+1)'({r_rx, 1'b0} >= {1'b0, r_d});
        n_qy = {1'b0, r_qy} + (hpm_pkg::QB+1)'({r_ry, 1'b0} >= {1'b0, r_d});
        n_satx = r_ovx || (r_negx ? (n_qx > (hpm_pkg::QB+1)'(34'h0_8000_0000))
                                  : (n_qx > (hpm_pkg::QB+1)'(34'h0_7FFF_FFFF)));
        n_saty = r_ovy || (r_negy ? (n_qy > (hpm_pkg::QB+1)'(34'h0_8000_0000))
                                  : (n_qy > (hpm_pkg::QB+1)'(34'h0_7FFF_FFFF)));
        if (n_satx) begin
            n_vx = r_negx ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_vx = r_negx ? -$signed(n_qx[hpm_pkg::PW-1:0])
                          : $signed(n_qx[hpm_pkg::PW-1:0]);
        end
        if (n_saty) begin
            n_vy = r_negy ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_vy = r_negy ? -$signed(n_qy[hpm_pkg::PW-1:0])
                          : $signed(n_qy[hpm_pkg::PW-1:0]);
        end
    end

    // control and coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_ov     <= 1'b0;
            for (int i = 0; i < hpm_pkg::NCOEF; i++) begin
                r_coef[i] <= hpm_pkg::coef_reset(hpm_pkg::IDXW'(i));
            end
        end else begin
            r_ov   <= (r_state == S_FIN && slot_free) || (r_ov && !i_pop);
            r_p1_v <= (r_state == S_MUL) && !r_issued;
            r_p2_v <= r_p1_v;
            case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        if (i_entry.is_map) begin
                            r_issued <= 1'b0;
                            r_state  <= S_MUL;
                        end else begin
                            r_coef[i_entry.idx] <= i_entry.coef;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_issued) begin
                        if (r_k == hpm_pkg::IDXW'(hpm_pkg::NCOEF - 1)) r_issued <= 1'b1;
                    end
                    if (n_drained) r_state <= S_MAG;
                end
                S_MAG: r_state <= S_CHK;
                S_CHK: r_state <= r_zero ? S_FIN : S_DIV;
                S_DIV: begin
                    if (r_cnt == hpm_pkg::CNTW'(hpm_pkg::QB - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // multiply, accumulate and divide datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x    <= i_entry.x;
                r_y    <= i_entry.y;
                r_last <= i_entry.last;
                r_k    <= '0;
                r_row  <= '0;
                r_col  <= '0;
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end
            S_MUL: begin
                if (!r_issued) begin
                    r_k <= r_k + 1'b1;
                    if (r_col == 2'd2) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
            S_MAG: begin
                r_nx   <= {n_ax[hpm_pkg::MW-1:0], hpm_pkg::PFB'(0)};
                r_ny   <= {n_ay[hpm_pkg::MW-1:0], hpm_pkg::PFB'(0)};
                r_d    <= n_az[hpm_pkg::MW-1:0];
                r_negx <= r_acc[0][hpm_pkg::ACCW-1] ^ r_acc[2][hpm_pkg::ACCW-1];
                r_negy <= r_acc[1][hpm_pkg::ACCW-1] ^ r_acc[2][hpm_pkg::ACCW-1];
                r_zero <= (r_acc[2] == '0);
            end
            S_CHK: begin
                r_ovx <= {hpm_pkg::QB'(0), r_nx} >= {hpm_pkg::PFB'(0), r_d, hpm_pkg::QB'(0)};
                r_ovy <= {hpm_pkg::QB'(0), r_ny} >= {hpm_pkg::PFB'(0), r_d, hpm_pkg::QB'(0)};
                r_rx  <= hpm_pkg::MW'(r_nx[hpm_pkg::NW-1:hpm_pkg::QB]);
                r_ry  <= hpm_pkg::MW'(r_ny[hpm_pkg::NW-1:hpm_pkg::QB]);
                r_lx  <= r_nx[hpm_pkg::QB-1:0];
                r_ly  <= r_ny[hpm_pkg::QB-1:0];
                r_qx  <= '0;
                r_qy  <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rx  <= n_gex ? n_subx[hpm_pkg::MW-1:0] : n_tx[hpm_pkg::MW-1:0];
                r_ry  <= n_gey ? n_suby[hpm_pkg::MW-1:0] : n_ty[hpm_pkg::MW-1:0];
                r_qx  <= {r_qx[hpm_pkg::QB-2:0], n_gex};
                r_qy  <= {r_qy[hpm_pkg::QB-2:0], n_gey};
                r_lx  <= r_lx << 1;
                r_ly  <= r_ly << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase

        // multiplier pipeline: split product, then recombine, then accumulate
        r_pp_hi  <= $signed(n_c[hpm_pkg::CW-1:hpm_pkg::CSPLIT]) * n_pt;
        r_pp_lo  <= $signed({1'b0, n_c[hpm_pkg::CSPLIT-1:0]}) * n_pt;
        r_p1_row <= r_row;
        r_prod   <= n_prod;
        r_p2_row <= r_p1_row;
        if (r_p2_v) begin
            r_acc[r_p2_row] <= r_acc[r_p2_row] + hpm_pkg::ACCW'(r_prod);
        end

        // output register
        if (r_state == S_FIN && slot_free) begin
            r_olast <= r_last;
            if (r_zero) begin
                r_ox  <= '0;
                r_oy  <= '0;
                r_ost <= hpm_pkg::ST_ZERO;
            end else begin
                r_ox  <= n_vx;
                r_oy  <= n_vy;
                r_ost <= (n_satx || n_saty) ? hpm_pkg::ST_SAT : hpm_pkg::ST_OK;
            end
        end
    end

    assign o_empty    = !r_ov;
    assign o_x_out    = r_ox;
    assign o_y_out    = r_oy;
    assign o_status   = r_ost;
    assign o_last_out = r_olast;

endmodule

@@ rtl/core/homography_point_map.sv @@
// ----------------------------------------------------------------------------
// homography_point_map
// Projective mapping of Q20.12 points through a 3x3 Q16.32 matrix.
// ----------------------------------------------------------------------------
// Requests enter a four-deep queue at one per cycle while it has room. A
// coefficient load is written to the matrix as the execution unit takes it
// from the queue. A point map is taken from the queue, makes nine passes
// through one shared split multiplier and waits for its pipeline to drain,
// sets up in S_MAG and S_CHK, runs 33 steps of the bit-serial dividers that
// form x/z and y/z side by side unless z is zero, and rounds in S_FIN. The
// result waits in an output register, so the next request is worked on
// while a result is not yet popped. The matrix resets to identity.
module homography_point_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_action,
    input  logic [hpm_pkg::IDXW-1:0]      i_coef_index,
    input  logic signed [hpm_pkg::CW-1:0] i_coef_value,
    input  logic signed [hpm_pkg::PW-1:0] i_x_in,
    input  logic signed [hpm_pkg::PW-1:0] i_y_in,
    input  logic                          i_last_in,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic signed [hpm_pkg::PW-1:0] o_x_out,
    output logic signed [hpm_pkg::PW-1:0] o_y_out,
    output logic [1:0]                    o_status,
    output logic                          o_last_out
);

    hpm_pkg::t_entry wr_entry;
    hpm_pkg::t_entry rd_entry;
    hpm_pkg::t_qstat qstat;
    logic            wr;
    logic            rd;

    // request intake
    hpm_front u_front (
        .i_push       (i_push),
        .i_action     (i_action),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_last_in    (i_last_in),
        .i_qstat      (qstat),
        .o_full       (o_full),
        .o_wr         (wr),
        .o_entry      (wr_entry)
    );

    // decoupling queue
    hpm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_entry (wr_entry),
        .i_rd    (rd),
        .o_entry (rd_entry),
        .o_qstat (qstat)
    );

    // execution
    hpm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (rd_entry),
        .i_qstat    (qstat),
        .o_rd       (rd),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_x_out    (o_x_out),
        .o_y_out    (o_y_out),
        .o_status   (o_status),
        .o_last_out (o_last_out)
    );

    // a zero-denominator result carries a zero point
    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == hpm_pkg::ST_ZERO) |-> (o_x_out == '0 && o_y_out == '0))
        else $error("zero denominator result with nonzero point");

    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.full |-> !wr)
        else $error("request queue overflow");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.empty |-> !rd)
        else $error("request queue underflow");

endmodule

@@ dv/tb_homography_point_map.sv @@
// ----------------------------------------------------------------------------
// tb_homography_point_map
// Checks the homography point mapper against its own exact fixed-point
// predictor: coefficient loads, identity, zero denominator, saturation,
// out-of-range loads, random matrices and points, with random idling on
// both sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_homography_point_map;

    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] xo;
        logic signed [31:0] yo;
        logic [1:0]         st;
        logic               lst;
    } t_mapped;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_push;
    logic                          o_full;
    logic                          i_action;
    logic [hpm_pkg::IDXW-1:0]      i_coef_index;
    logic signed [hpm_pkg::CW-1:0] i_coef_value;
    logic signed [hpm_pkg::PW-1:0] i_x_in;
    logic signed [hpm_pkg::PW-1:0] i_y_in;
    logic                          i_last_in;
    logic                          o_empty;
    logic                          i_pop;
    logic signed [hpm_pkg::PW-1:0] o_x_out;
    logic signed [hpm_pkg::PW-1:0] o_y_out;
    logic [1:0]                    o_status;
    logic                          o_last_out;

    homography_point_map dut (.*);

    // predictor state and expected results
    logic signed [hpm_pkg::CW-1:0] matrix [hpm_pkg::NCOEF];
    t_mapped  pending_points [$];
    int       n_fail;
    int       n_maps;
    int       n_loads;
    int       n_zero;
    int       n_sat;
    int       cycles;
    bit       hold_pop;
    bit       busy_rx;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("homography_point_map: mismatch");
            $finish;
        end
    end

    // divide one exact sum by z, round half away, saturate
    function automatic logic [31:0] div_round(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout bit sat);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic [127:0] r;
        bit           neg;
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        nm = nm << hpm_pkg::PFB;
        q = nm / dm;
        r = nm % dm;
        if ((r << 1) >= dm) q = q + 1;
        if (!neg) begin
            if (q > 128'h7FFFFFFF) begin
                sat = 1;
                return 32'h7FFFFFFF;
            end
            return q[31:0];
        end
        if (q > 128'h80000000) begin
            sat = 1;
            return 32'h80000000;
        end
        return -q[31:0];
    endfunction

    // exact affine sum of one matrix row
    function automatic logic signed [127:0] row_sum(input int row,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
        logic signed [127:0] a;
        a = 128'(matrix[row*3]) * 128'(x) + 128'(matrix[row*3+1]) * 128'(y)
            + (128'(matrix[row*3+2]) <<< hpm_pkg::PFB);
        return a;
    endfunction

    // apply one request to the predictor
    task automatic predict(input bit act, input logic [3:0] idx,
                           input logic signed [47:0] cv, input logic signed [31:0] x,
                           input logic signed [31:0] y, input bit lst);
        logic signed [127:0] sx;
        logic signed [127:0] sy;
        logic signed [127:0] sz;
        t_mapped m;
        bit sat;
        if (!act) begin
            if (idx < hpm_pkg::NCOEF) matrix[idx] = cv;
            n_loads++;
            return;
        end
        n_maps++;
        sx = row_sum(0, x, y);
        sy = row_sum(1, x, y);
        sz = row_sum(2, x, y);
        m.lst = lst;
        sat = 0;
        if (sz == 0) begin
            m.xo = '0;
            m.yo = '0;
            m.st = hpm_pkg::ST_ZERO;
            n_zero++;
        end else begin
            m.xo = div_round(sx, sz, sat);
            m.yo = div_round(sy, sz, sat);
            m.st = sat ? hpm_pkg::ST_SAT : hpm_pkg::ST_OK;
            if (sat) n_sat++;
        end
        pending_points.push_back(m);
    endtask

    // send one request, waiting for room
    task automatic send(input bit act, input logic [3:0] idx,
                        input logic signed [47:0] cv, input logic signed [31:0] x,
                        input logic signed [31:0] y, input bit lst);
        int gap;
        i_push <= 1'b1;
        i_action <= act;
        i_coef_index <= idx;
        i_coef_value <= cv;
        i_x_in <= x;
        i_y_in <= y;
        i_last_in <= lst;
        do @(posedge i_clk); while (o_full);
        predict(act, idx, cv, x, y, lst);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load(input logic [3:0] idx, input logic signed [47:0] cv);
        send(1'b0, idx, cv, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic map_point(input logic signed [31:0] x, input logic signed [31:0] y);
        send(1'b1, 4'($urandom), 48'({$urandom, $urandom}), x, y,
             1'($urandom_range(0, 1)));
    endtask

    // wait for all results, then let the block finish any load
    task automatic drain();
        i_push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_point();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 8191)) - 4096;
            3: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [47:0] rand_coef();
        case ($urandom_range(0, 6))
            0: return 48'sh7FFFFFFFFFFF;
            1: return 48'sh800000000000;
            2: return 48'sh0;
            3: return $signed(48'($urandom_range(0, 65535))) <<< 20;
            4: return (48'sd1 <<< hpm_pkg::CFB) + $signed(48'($urandom_range(0, 4095))) - 2048;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // result checker, run on each accepted pop
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_points.size() == 0) begin
                $error("result with none expected: x %0d y %0d", o_x_out, o_y_out);
                n_fail++;
            end else begin
                t_mapped e;
                e = pending_points.pop_front();
                if (o_x_out !== e.xo) begin
                    $error("x_out exp %0d got %0d", e.xo, o_x_out);
                    n_fail++;
                end
                if (o_y_out !== e.yo) begin
                    $error("y_out exp %0d got %0d", e.yo, o_y_out);
                    n_fail++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status);
                    n_fail++;
                end
                if (o_last_out !== e.lst) begin
                    $error("last_out exp %0d got %0d", e.lst, o_last_out);
                    n_fail++;
                end
            end
        end
    end

    // pop pacing: mostly ready, short and rare long stalls, or a forced hold
    initial begin
        int stall;
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_pop) begin
                i_pop <= 1'b0;
            end else if (!busy_rx && $urandom_range(0, 99) < 4) begin
                busy_rx = 1;
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 200);
                i_pop <= 1'b0;
                fork
                    begin
                        repeat (stall) @(posedge i_clk);
                        busy_rx = 0;
                    end
                join_none
            end else if (!busy_rx) begin
                i_pop <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic test_identity();
        map_point(32'sh00001000, 32'sh00002000);
        map_point(32'sh7FFFFFFF, 32'sh80000000);
        map_point(32'sh0, 32'sh0);
        map_point(32'shFFFFFFFF, 32'sh00000001);
        drain();
    endtask

    task automatic test_special();
        // out-of-range index leaves the matrix alone
        load(4'd9, 48'sh123456789ABC);
        load(4'd15, 48'sh7FFFFFFFFFFF);
        map_point(32'sh00003000, 32'shFFFFD000);
        // zero denominator
        load(4'd8, 48'sh0);
        map_point(32'sh0, 32'sh0);
        // saturation high and low
        load(4'd8, 48'sh000000000001);
        load(4'd0, 48'sh7FFFFFFFFFFF);
        load(4'd4, 48'sh800000000000);
        map_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        map_point(32'sh80000000, 32'sh00001000);
        // negative denominator, halves
        load(4'd6, 48'sh800000000000);
        load(4'd7, 48'sh7FFFFFFFFFFF);
        load(4'd1, 48'sh000080000000);
        load(4'd2, 48'shFFFF00000000);
        load(4'd3, 48'sh000000000003);
        load(4'd5, 48'shFFFFFFFFFFFF);
        map_point(32'sh80000000, 32'sh7FFFFFFF);
        drain();
    endtask

    task automatic test_random(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) load(4'($urandom_range(0, 15)), rand_coef());
            else map_point(rand_point(), rand_point());
        end
        drain();
    endtask

    task automatic test_backpressure();
        int k;
        hold_pop = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_pop = 0;
            end
        join_none
        for (k = 0; k < 20; k++) map_point(rand_point(), rand_point());
        drain();
    endtask

    initial begin
        int k;
        n_fail = 0; n_maps = 0; n_loads = 0; n_zero = 0; n_sat = 0;
        cycles = 0; hold_pop = 0; busy_rx = 0;
        for (k = 0; k < hpm_pkg::NCOEF; k++) begin
            matrix[k] = hpm_pkg::coef_reset(hpm_pkg::IDXW'(k));
        end
        i_rst_n <= 1'b0;
        i_push <= 1'b0;
        i_action <= 1'b0;
        i_coef_index <= '0;
        i_coef_value <= '0;
        i_x_in <= '0;
        i_y_in <= '0;
        i_last_in <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity();
        test_special();
        test_backpressure();
        test_random(1200);
        $display("covered %0d maps, %0d loads, %0d zero denominators, %0d saturations",
                 n_maps, n_loads, n_zero, n_sat);
        if (n_fail == 0) begin
            $display("homography_point_map: match");
        end else begin
            $display("homography_point_map: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/hpm_pkg.sv
rtl/core/hpm_front.sv
rtl/core/hpm_fifo.sv
rtl/core/hpm_back.sv
rtl/core/homography_point_map.sv
dv/tb_homography_point_map.sv
